FILE: sv/step_response_metrics_defines.svh
// assertion macros shared by the step response metrics rtl
`ifndef STEP_RESPONSE_METRICS_DEFINES_SVH
`define STEP_RESPONSE_METRICS_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SRM_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srm check failed");
// antecedent implies consequent in the next cycle
`define SRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srm check failed");
`else
`define SRM_ASSERT_IMPLIES(lbl, ante, cons)
`define SRM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/srm_pkg.sv
// types and constants shared by the step response metrics rtl
`timescale 1ns / 1ps
package srm_pkg;

    // fixed point and angle constants
    localparam int FRAC_BITS   = 8;
    localparam int DEG_TURN    = 360;
    localparam int DEG_BITS    = 9;
    localparam int HALF_TURN   = 180 * 256;
    localparam int FULL_TURN   = 360 * 256;
    localparam int PERIOD_BITS = 10;

    // configuration register reset values
    localparam int ANGULAR_RESET = 1;
    localparam int BAND_RESET    = 384;
    localparam int HOLD_RESET    = 250;
    localparam int PERIOD_RESET  = 20;
    localparam int FIRST_RESET   = 1;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ANGULAR_MODE = 3'd0,
        CFG_SETTLE_BAND  = 3'd1,
        CFG_HOLD_TIME    = 3'd2,
        CFG_SAMPLE_PER   = 3'd3,
        CFG_INIT_FIRST   = 3'd4
    } cfg_index_t;

    typedef enum logic {
        FUNC_START  = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    // pipeline control towards the error path
    typedef struct packed {
        logic s0_valid;
        logic s1_en;
        logic s2_en;
    } err_ctrl_t;

endpackage

FILE: sv/srm_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
interface srm_in_if #(
    parameter int VALUE_BITS = 22,
    parameter int TIME_BITS  = 16
);
    import srm_pkg::*;

    logic                         valid;
    logic                         ready;
    func_t                        func;
    logic signed [VALUE_BITS-1:0] target;
    logic signed [VALUE_BITS-1:0] start_value;
    logic signed [VALUE_BITS-1:0] actual;
    logic [TIME_BITS-1:0]         elapsed_ms;

    modport source (output valid, func, target, start_value, actual, elapsed_ms,
                    input ready);
    modport sink (input valid, func, target, start_value, actual, elapsed_ms,
                  output ready);
endinterface

interface srm_out_if #(
    parameter int VALUE_BITS = 22,
    parameter int TIME_BITS  = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_BITS:0] error;
    logic [VALUE_BITS:0]        overshoot;
    logic signed [TIME_BITS:0]  settle_ms;
    logic                       crossed;

    modport source (output valid, error, overshoot, settle_ms, crossed, input ready);
    modport sink (input valid, error, overshoot, settle_ms, crossed, output ready);
endinterface

FILE: sv/srm_error_path.sv
// error forming with turn wrap, two register stages
`timescale 1ns / 1ps
module srm_error_path #(
    parameter int VALUE_BITS = 22
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  srm_pkg::err_ctrl_t           ctrl,
    input  logic                         angular_mode,
    input  srm_pkg::func_t               func,
    input  logic signed [VALUE_BITS-1:0] target,
    input  logic signed [VALUE_BITS-1:0] start_value,
    input  logic signed [VALUE_BITS-1:0] actual,
    output logic signed [VALUE_BITS:0]   err
);
    import srm_pkg::*;

    localparam int EW = VALUE_BITS + 1;
    localparam int HB = EW - FRAC_BITS;
    localparam int UB = HB + 1;
    localparam int WW = EW + 2;
    localparam int SH = UB + DEG_BITS;
    localparam int RB = UB + 1;
    localparam int PB = SH + DEG_BITS;
    localparam longint OFF_TURNS = ((longint'(1) <<< (HB - 1)) + DEG_TURN - 1) / DEG_TURN;
    localparam longint RECIP = ((longint'(1) <<< SH) + DEG_TURN - 1) / DEG_TURN;
    localparam logic [UB-1:0] OFFSET_W = UB'(OFF_TURNS * DEG_TURN);
    localparam logic [RB-1:0] RECIP_W = RB'(RECIP);
    localparam logic signed [EW-1:0] HALF_E = EW'(HALF_TURN);
    localparam logic signed [WW-1:0] HALF_W = WW'(HALF_TURN);
    localparam logic signed [WW-1:0] FULL_W = WW'(FULL_TURN);

    logic signed [VALUE_BITS-1:0] run_target_reg;
    logic signed [VALUE_BITS-1:0] tgt_sel;
    logic signed [VALUE_BITS-1:0] val_sel;
    logic signed [EW-1:0]         diff;
    logic signed [HB-1:0]         hi;
    logic [UB-1:0]                u_val;
    logic [PB-1:0]                prod;

    logic signed [EW-1:0]  d1_reg;
    logic [DEG_BITS-1:0]   u_lo1_reg;
    logic [DEG_BITS-1:0]   q1_reg;
    logic                  gt1_reg;
    logic                  lt1_reg;
    logic                  ang1_reg;

    logic [DEG_BITS-1:0]   q_mul;
    logic [DEG_BITS-1:0]   r_deg;
    logic signed [WW-1:0]  rw;
    logic signed [WW-1:0]  wrapped;
    logic signed [EW-1:0]  err_next;
    logic signed [EW-1:0]  err2_reg;

    // run target follows each start request as it leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_target_reg <= '0;
        end
        else if (ctrl.s1_en && ctrl.s0_valid && func == FUNC_START)
        begin
            run_target_reg <= target;
        end
    end

    // difference and reciprocal multiply for the whole degrees
    always_comb
    begin
        tgt_sel = (func == FUNC_START) ? target : run_target_reg;
        val_sel = (func == FUNC_START) ? start_value : actual;
        diff    = EW'(tgt_sel) - EW'(val_sel);
        hi      = diff[EW-1:FRAC_BITS];
        u_val   = UB'(hi) + OFFSET_W;
        prod    = PB'(u_val) * PB'(RECIP_W);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_en)
        begin
            d1_reg    <= diff;
            u_lo1_reg <= u_val[DEG_BITS-1:0];
            q1_reg    <= prod[SH +: DEG_BITS];
            gt1_reg   <= diff > HALF_E;
            lt1_reg   <= diff < -HALF_E;
            ang1_reg  <= angular_mode;
        end
    end

    // remainder within one turn, then pick the wrapped value
    always_comb
    begin
        q_mul = q1_reg * DEG_BITS'(DEG_TURN);
        r_deg = u_lo1_reg - q_mul;
        rw    = $signed(WW'({r_deg, d1_reg[FRAC_BITS-1:0]}));
        if (gt1_reg)
        begin
            wrapped = (rw <= HALF_W) ? rw : rw - FULL_W;
        end
        else if (lt1_reg)
        begin
            wrapped = (rw < HALF_W) ? rw : rw - FULL_W;
        end
        else
        begin
            wrapped = WW'(d1_reg);
        end
        err_next = ang1_reg ? EW'(wrapped) : d1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s2_en)
        begin
            err2_reg <= err_next;
        end
    end

    assign err = err2_reg;

endmodule

FILE: sv/srm_metrics.sv
// crossing, overshoot and settle tracking with result registers
`timescale 1ns / 1ps
`include "step_response_metrics_defines.svh"
module srm_metrics #(
    parameter int VALUE_BITS = 22,
    parameter int TIME_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  srm_pkg::func_t                func,
    input  logic signed [VALUE_BITS:0]    err,
    input  logic [TIME_BITS-1:0]          elapsed,
    input  logic [VALUE_BITS-1:0]         settle_band,
    input  logic [TIME_BITS-1:0]          hold_time,
    input  logic [srm_pkg::PERIOD_BITS-1:0] sample_period,
    input  logic                          init_first,
    output logic signed [VALUE_BITS:0]    error,
    output logic [VALUE_BITS:0]           overshoot,
    output logic signed [TIME_BITS:0]     settle_ms,
    output logic                          crossed
);
    import srm_pkg::*;

    localparam int EW = VALUE_BITS + 1;

    logic signed [EW-1:0]  initial_error_reg, initial_error_next;
    logic                  awaiting_reg, awaiting_next;
    logic                  crossed_reg, crossed_next;
    logic [EW-1:0]         worst_reg, worst_next;
    logic [TIME_BITS-1:0]  in_band_reg, in_band_next;
    logic                  settled_reg, settled_next;
    logic [TIME_BITS-1:0]  settle_val_reg, settle_val_next;
    logic signed [EW-1:0]  err_out_reg;

    logic [EW-1:0]         mag;
    logic signed [EW-1:0]  ie_eff;
    logic                  in_band;
    logic [TIME_BITS:0]    band_sum;
    logic [TIME_BITS-1:0]  band_sat;
    logic [TIME_BITS:0]    since_hold;
    logic [TIME_BITS-1:0]  settle_calc;

    // next run state for one request
    always_comb
    begin
        mag         = err[EW-1] ? EW'(-err) : EW'(err);
        ie_eff      = (awaiting_reg && init_first) ? err : initial_error_reg;
        in_band     = mag < {1'b0, settle_band};
        band_sum    = {1'b0, in_band_reg} + (TIME_BITS+1)'(sample_period);
        band_sat    = band_sum[TIME_BITS] ? '1 : band_sum[TIME_BITS-1:0];
        since_hold  = {1'b0, elapsed} - {1'b0, hold_time};
        settle_calc = since_hold[TIME_BITS] ? '0 : since_hold[TIME_BITS-1:0];

        initial_error_next = initial_error_reg;
        awaiting_next      = awaiting_reg;
        crossed_next       = crossed_reg;
        worst_next         = worst_reg;
        in_band_next       = in_band_reg;
        settled_next       = settled_reg;
        settle_val_next    = settle_val_reg;

        if (func == FUNC_START)
        begin
            initial_error_next = err;
            awaiting_next      = 1'b1;
            crossed_next       = 1'b0;
            worst_next         = '0;
            in_band_next       = '0;
            settled_next       = 1'b0;
        end
        else
        begin
            initial_error_next = ie_eff;
            awaiting_next      = 1'b0;
            if (!crossed_reg && ie_eff != 0 && (err == 0 || ((err > 0) != (ie_eff > 0))))
            begin
                crossed_next = 1'b1;
            end
            if (crossed_next && mag > worst_reg)
            begin
                worst_next = mag;
            end
            if (in_band)
            begin
                in_band_next = band_sat;
                if (band_sat >= hold_time && !settled_reg)
                begin
                    settled_next    = 1'b1;
                    settle_val_next = settle_calc;
                end
            end
            else
            begin
                in_band_next = '0;
                settled_next = 1'b0;
            end
        end
    end

    // run state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_error_reg <= '0;
            awaiting_reg      <= 1'b1;
            crossed_reg       <= 1'b0;
            worst_reg         <= '0;
            in_band_reg       <= '0;
            settled_reg       <= 1'b0;
        end
        else if (take)
        begin
            initial_error_reg <= initial_error_next;
            awaiting_reg      <= awaiting_next;
            crossed_reg       <= crossed_next;
            worst_reg         <= worst_next;
            in_band_reg       <= in_band_next;
            settled_reg       <= settled_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            settle_val_reg <= settle_val_next;
            err_out_reg    <= err;
        end
    end

    assign error     = err_out_reg;
    assign overshoot = worst_reg;
    assign settle_ms = settled_reg ? $signed({1'b0, settle_val_reg}) : '1;
    assign crossed   = crossed_reg;

    // checks
    `SRM_ASSERT_IMPLIES(a_no_cross_no_peak, !crossed_reg, worst_reg == '0)
    `SRM_ASSERT_NEXT(a_hold_when_idle, !take, $stable(worst_reg) && $stable(crossed_reg))
    `SRM_ASSERT_IMPLIES(a_cross_on_take, $rose(crossed_reg), $past(take))

endmodule

FILE: sv/step_response_metrics.sv
// top level of the step response metrics block
//
//  channel  dir  handshake     payload
//  item     in   valid/ready   func target start_value actual elapsed_ms
//  result   out  valid/ready   error overshoot settle_ms crossed
//  cfg      in   cfg_we        cfg_index cfg_data (write only)
//
// one request per cycle sustained while the result channel is ready; a taken request passes
// the input, difference/multiply, wrap and state update stages in order before its result appears
// the run state update in the metrics stage feeds back on its own registers
// reset puts the run state in its start values and loads the register defaults
// stages fill bubbles on a stalled result; ready drops only with all four full
`timescale 1ns / 1ps
`include "step_response_metrics_defines.svh"
module step_response_metrics #(
    parameter int VALUE_BITS = 22,
    parameter int TIME_BITS  = 16,
    localparam int CFG_BITS_A = (VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS,
    localparam int CFG_BITS = (CFG_BITS_A > srm_pkg::PERIOD_BITS) ?
                              CFG_BITS_A : srm_pkg::PERIOD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    srm_in_if.sink                            item,
    srm_out_if.source                         result,
    input  logic                              cfg_we,
    input  logic [srm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]               cfg_data
);
    import srm_pkg::*;

    localparam logic signed [VALUE_BITS:0] HALF_E = (VALUE_BITS+1)'(HALF_TURN);

    logic                    angular_mode_reg;
    logic [VALUE_BITS-1:0]   settle_band_reg;
    logic [TIME_BITS-1:0]    hold_time_reg;
    logic [PERIOD_BITS-1:0]  sample_period_reg;
    logic                    init_first_reg;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic free0, free1, free2, free3;

    func_t                        func0_reg, func1_reg, func2_reg;
    logic signed [VALUE_BITS-1:0] target0_reg;
    logic signed [VALUE_BITS-1:0] start0_reg;
    logic signed [VALUE_BITS-1:0] actual0_reg;
    logic [TIME_BITS-1:0]         elapsed0_reg, elapsed1_reg, elapsed2_reg;

    err_ctrl_t                    ectrl;
    logic signed [VALUE_BITS:0]   path_err;
    logic                         take;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angular_mode_reg  <= 1'(ANGULAR_RESET);
            settle_band_reg   <= VALUE_BITS'(BAND_RESET);
            hold_time_reg     <= TIME_BITS'(HOLD_RESET);
            sample_period_reg <= PERIOD_BITS'(PERIOD_RESET);
            init_first_reg    <= 1'(FIRST_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ANGULAR_MODE: angular_mode_reg  <= cfg_data[0];
                CFG_SETTLE_BAND:  settle_band_reg   <= cfg_data[VALUE_BITS-1:0];
                CFG_HOLD_TIME:    hold_time_reg     <= cfg_data[TIME_BITS-1:0];
                CFG_SAMPLE_PER:   sample_period_reg <= cfg_data[PERIOD_BITS-1:0];
                CFG_INIT_FIRST:   init_first_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // stage flow control, each stage loads when it is empty or draining
    assign free3 = !v3_reg || result.ready;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;
    assign free0 = !v0_reg || free1;
    assign item.ready = free0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (free0)
            begin
                v0_reg <= item.valid;
            end
            if (free1)
            begin
                v1_reg <= v0_reg;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // input stage and side payload carried alongside the error path
    always_ff @(posedge clk)
    begin
        if (free0)
        begin
            func0_reg    <= item.func;
            target0_reg  <= item.target;
            start0_reg   <= item.start_value;
            actual0_reg  <= item.actual;
            elapsed0_reg <= item.elapsed_ms;
        end
        if (free1)
        begin
            func1_reg    <= func0_reg;
            elapsed1_reg <= elapsed0_reg;
        end
        if (free2)
        begin
            func2_reg    <= func1_reg;
            elapsed2_reg <= elapsed1_reg;
        end
    end

    assign ectrl.s0_valid = v0_reg;
    assign ectrl.s1_en    = free1;
    assign ectrl.s2_en    = free2;

    srm_error_path #(
        .VALUE_BITS (VALUE_BITS)
    ) u_error_path (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ectrl),
        .angular_mode (angular_mode_reg),
        .func         (func0_reg),
        .target       (target0_reg),
        .start_value  (start0_reg),
        .actual       (actual0_reg),
        .err          (path_err)
    );

    assign take = v2_reg && free3;

    srm_metrics #(
        .VALUE_BITS (VALUE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_metrics (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .func          (func2_reg),
        .err           (path_err),
        .elapsed       (elapsed2_reg),
        .settle_band   (settle_band_reg),
        .hold_time     (hold_time_reg),
        .sample_period (sample_period_reg),
        .init_first    (init_first_reg),
        .error         (result.error),
        .overshoot     (result.overshoot),
        .settle_ms     (result.settle_ms),
        .crossed       (result.crossed)
    );

    assign result.valid = v3_reg;

    // checks
    `SRM_ASSERT_IMPLIES(a_stall_full, !item.ready, v0_reg && v1_reg && v2_reg && v3_reg)
    `SRM_ASSERT_IMPLIES(a_wrap_range, v2_reg && angular_mode_reg, (path_err <= HALF_E) && (path_err >= -HALF_E))
    `SRM_ASSERT_NEXT(a_result_fill, v2_reg && !v3_reg, v3_reg)

endmodule
